/* src/utf8_to_utf16_bmp_decoder_core_defines.svh */
// assertion macros for the utf-8 to utf-16 decoder
`ifndef UTF8_TO_UTF16_BMP_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_BMP_DECODER_CORE_DEFINES_SVH

// combinational property checked at every rising clock edge outside reset
`define U8U16_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/u8u16dec_pkg.sv */
// types and byte-class constants for the utf-8 to utf-16 decoder
package u8u16dec_pkg;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_TWO_LAST   = 2'd1,
        PH_THREE_MID  = 2'd2,
        PH_THREE_LAST = 2'd3
    } phase_t;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] MASK_TOP2 = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] MASK_TOP3 = 8'hE0;
    localparam logic [7:0] LEAD2_TAG = 8'hC0;
    localparam logic [7:0] MASK_TOP4 = 8'hF0;
    localparam logic [7:0] LEAD3_TAG = 8'hE0;

endpackage

/* src/utf8_to_utf16_bmp_decoder_core.sv */
// utf-8 to utf-16 decoder core, basic multilingual plane only
// an accepted byte passes the registered input stage and then the registered result stage
// throughput: one byte per cycle while byte_stall is low, set by the combinational phase and bit merge
// a byte that completes no unit and is not the last gives no result
// reset (rst_n low, asynchronous) empties both stages and returns to idle phase
`include "utf8_to_utf16_bmp_decoder_core_defines.svh"

module utf8_to_utf16_bmp_decoder_core
    import u8u16dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        final_byte,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic        has_unit,
    output logic        string_end
);

    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         s1_final_reg;
    phase_t       phase_reg;
    phase_t       phase_next;
    logic [9:0]   partial_reg;
    logic [9:0]   partial_next;
    logic         out_valid_reg;
    logic [15:0]  code_unit_reg;
    logic         has_unit_reg;
    logic         string_end_reg;

    logic         is_cont;
    logic         is_ascii;
    logic         is_lead2;
    logic         is_lead3;
    logic         got;
    logic [15:0]  unit;
    logic         emit;
    logic         out_free;
    logic         s1_fire;
    logic         accept;

    assign is_cont  = (s1_byte_reg & MASK_TOP2) == CONT_TAG;
    assign is_ascii = s1_byte_reg <= ASCII_MAX;
    assign is_lead2 = (s1_byte_reg & MASK_TOP3) == LEAD2_TAG;
    assign is_lead3 = (s1_byte_reg & MASK_TOP4) == LEAD3_TAG;

    assign emit       = got || s1_final_reg;
    assign out_free   = !out_valid_reg || !unit_stall;
    assign s1_fire    = s1_valid_reg && (!emit || out_free);
    assign byte_stall = s1_valid_reg && !s1_fire;
    assign accept     = byte_valid && !byte_stall;

    // next phase and gathered bits
    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        if (phase_reg == PH_IDLE || !is_cont)
        begin
            // fresh decode, also after a broken sequence
            phase_next   = PH_IDLE;
            partial_next = '0;
            if (!is_ascii && is_lead2)
            begin
                phase_next   = PH_TWO_LAST;
                partial_next = {5'd0, s1_byte_reg[4:0]};
            end
            else if (!is_ascii && is_lead3)
            begin
                phase_next   = PH_THREE_MID;
                partial_next = {6'd0, s1_byte_reg[3:0]};
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_THREE_MID:
                begin
                    phase_next   = PH_THREE_LAST;
                    partial_next = {partial_reg[3:0], s1_byte_reg[5:0]};
                end
                PH_TWO_LAST, PH_THREE_LAST, PH_IDLE:
                begin
                    phase_next   = PH_IDLE;
                    partial_next = '0;
                end
            endcase
        end
        if (s1_final_reg)
        begin
            phase_next   = PH_IDLE;
            partial_next = '0;
        end
    end

    // decoded unit for the byte in the input stage
    always_comb
    begin
        got  = 1'b0;
        unit = '0;
        if (phase_reg == PH_IDLE || !is_cont)
        begin
            if (is_ascii)
            begin
                got  = 1'b1;
                unit = {8'd0, s1_byte_reg};
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TWO_LAST:
                begin
                    got  = 1'b1;
                    unit = {5'd0, partial_reg[4:0], s1_byte_reg[5:0]};
                end
                PH_THREE_LAST:
                begin
                    got  = 1'b1;
                    unit = {partial_reg, s1_byte_reg[5:0]};
                end
                PH_THREE_MID, PH_IDLE:
                begin
                    got  = 1'b0;
                    unit = '0;
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= in_byte;
            s1_final_reg <= final_byte;
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            partial_reg <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_fire && emit)
        begin
            code_unit_reg  <= unit;
            has_unit_reg   <= got;
            string_end_reg <= s1_final_reg;
        end
    end

    assign unit_valid = out_valid_reg;
    assign code_unit  = code_unit_reg;
    assign has_unit   = has_unit_reg;
    assign string_end = string_end_reg;

    `U8U16_ASSERT_NOW(a_empty_unit_zero, !(out_valid_reg && !has_unit_reg) || (code_unit_reg == 16'd0), "end-only result carries a nonzero code unit")
    `U8U16_ASSERT_NOW(a_empty_only_at_end, !(out_valid_reg && !has_unit_reg) || string_end_reg, "result without unit outside string end")
    `U8U16_ASSERT_NEXT(a_final_to_idle, s1_fire && s1_final_reg, phase_reg == PH_IDLE && partial_reg == 10'd0, "sequence state not cleared after last byte")
    `U8U16_ASSERT_NEXT(a_emit_reaches_output, s1_fire && emit, out_valid_reg, "result lost between stages")

endmodule
